// ===== rtl/vector3_normalize_defines.svh =====
// Assertion macros for the vector normalizer.
// The including module must provide clk and rst_n.
`ifndef VECTOR3_NORMALIZE_DEFINES_SVH
`define VECTOR3_NORMALIZE_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define VN_ASSERT_SAME(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("vector3_normalize: same-cycle check failed");

// The condition must hold in the cycle after the trigger.
`define VN_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("vector3_normalize: next-cycle check failed");

`endif

// ===== rtl/vn_pkg.sv =====
// Shared widths and constants for the vector normalizer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vn_pkg;
    localparam int FRAC_BITS = 16;
    localparam int IN_W      = 24;
    localparam int OUT_W     = FRAC_BITS + 2;
    localparam int ABS_W     = IN_W;
    localparam int SQ_W      = 2 * ABS_W;
    localparam int MAG_W     = SQ_W / 2;
    localparam int CFG_W     = 16;
    localparam int Q_W       = FRAC_BITS + 1;
    localparam int NUM_W     = ABS_W + FRAC_BITS;
    localparam int REM_W     = MAG_W + 2;
    localparam logic [CFG_W-1:0] MIN_MAG_RESET = 16'd7;
    localparam logic [Q_W-1:0]   UNIT_ONE = Q_W'(1) << FRAC_BITS;
endpackage
`default_nettype wire

// ===== rtl/vn_if.sv =====
// Request channel interfaces for the vector normalizer.
// Depends on vn_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface vn_in_if;
    logic valid;
    logic ready;
    logic signed [vn_pkg::IN_W-1:0] x_in;
    logic signed [vn_pkg::IN_W-1:0] y_in;
    logic signed [vn_pkg::IN_W-1:0] z_in;
    modport source (output valid, output x_in, output y_in, output z_in, input ready);
    modport sink (input valid, input x_in, input y_in, input z_in, output ready);
endinterface

interface vn_out_if;
    logic valid;
    logic ready;
    logic signed [vn_pkg::OUT_W-1:0] x_unit;
    logic signed [vn_pkg::OUT_W-1:0] y_unit;
    logic signed [vn_pkg::OUT_W-1:0] z_unit;
    logic too_short;
    modport source (output valid, output x_unit, output y_unit, output z_unit,
                    output too_short, input ready);
    modport sink (input valid, input x_unit, input y_unit, input z_unit,
                  input too_short, output ready);
endinterface

interface vn_cfg_if;
    logic valid;
    logic ready;
    logic [vn_pkg::CFG_W-1:0] min_magnitude;
    modport source (output valid, output min_magnitude, input ready);
    modport sink (input valid, input min_magnitude, output ready);
endinterface
`default_nettype wire

// ===== rtl/vector3_normalize.sv =====
// Top level of the 3D vector normalizer: squares, root, divide, round.
// Depends on vn_pkg, vn_if.sv and vector3_normalize_defines.svh.
//
//  Channel   Dir  Payload                                  Handshake
//  vec_in    in   x_in, y_in, z_in (Q8.16)                 valid/ready
//  vec_out   out  x_unit, y_unit, z_unit (Q2.16), too_short valid/ready
//  cfg       in   min_magnitude (Q0.16 threshold)          valid/ready
//
// One request enters per cycle unless the output stalls; each result passes
// through input, square, sum, 24 root stages, threshold, 17 divide stages, output.
// Each root stage yields one root bit and each divide stage one quotient bit.
// The whole pipeline halts together while a result waits at the output.
// Reset clears all valid bits and sets the threshold to 7.
`timescale 1ns / 1ps
`default_nettype none
`include "vector3_normalize_defines.svh"
module vector3_normalize (
    input  wire logic clk,
    input  wire logic rst_n,
    vn_in_if.sink     vec_in,
    vn_out_if.source  vec_out,
    vn_cfg_if.sink    cfg
);
    localparam int ABS_W = vn_pkg::ABS_W;
    localparam int SQ_W  = vn_pkg::SQ_W;
    localparam int MAG_W = vn_pkg::MAG_W;
    localparam int REM_W = vn_pkg::REM_W;
    localparam int Q_W   = vn_pkg::Q_W;
    localparam int NUM_W = vn_pkg::NUM_W;
    localparam int OUT_W = vn_pkg::OUT_W;
    localparam int RS    = MAG_W;
    localparam int DS    = Q_W;

    logic adv;
    logic [vn_pkg::CFG_W-1:0] min_mag_reg;

    // Stage A: absolute values and signs.
    logic             a_vld_reg;
    logic [ABS_W-1:0] a_abs_reg [3];
    logic [2:0]       a_sgn_reg;
    // Stage B: squares.
    logic             b_vld_reg;
    logic [SQ_W-1:0]  b_sq_reg [3];
    logic [ABS_W-1:0] b_abs_reg [3];
    logic [2:0]       b_sgn_reg;

    // Root stages; entry 0 holds the sum of squares.
    logic             r_vld_reg  [RS+1];
    logic [SQ_W-1:0]  r_n_reg    [RS+1];
    logic [REM_W-1:0] r_rem_reg  [RS+1];
    logic [MAG_W-1:0] r_root_reg [RS+1];
    logic [ABS_W-1:0] r_abs_reg  [RS+1][3];
    logic [2:0]       r_sgn_reg  [RS+1];
    logic [SQ_W-1:0]  r_n_next    [RS+1];
    logic [REM_W-1:0] r_rem_next  [RS+1];
    logic [MAG_W-1:0] r_root_next [RS+1];

    // Divide stages; entry 0 holds the threshold result and numerators.
    logic             d_vld_reg   [DS+1];
    logic [MAG_W-1:0] d_mag_reg   [DS+1];
    logic             d_short_reg [DS+1];
    logic [2:0]       d_sgn_reg   [DS+1];
    logic [MAG_W-1:0] d_rem_reg   [DS+1][3];
    logic [Q_W-1:0]   d_low_reg   [DS+1][3];
    logic [Q_W-1:0]   d_q_reg     [DS+1][3];
    logic [MAG_W-1:0] d_rem_next  [DS+1][3];
    logic [Q_W-1:0]   d_low_next  [DS+1][3];
    logic [Q_W-1:0]   d_q_next    [DS+1][3];

    logic [NUM_W-1:0] num_next [3];
    logic [MAG_W-1:0] fin_mag;

    logic             o_vld_reg;
    logic [OUT_W-1:0] o_unit_reg [3];
    logic [OUT_W-1:0] o_unit_next [3];
    logic             o_short_reg;

    logic signed [vn_pkg::IN_W-1:0] comp_in [3];

    logic out_zero;
    logic out_in_range;
    logic out_stall;

    assign adv          = !o_vld_reg || vec_out.ready;
    assign vec_in.ready = adv;
    assign cfg.ready    = 1'b1;
    assign comp_in[0]   = vec_in.x_in;
    assign comp_in[1]   = vec_in.y_in;
    assign comp_in[2]   = vec_in.z_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_mag_reg <= vn_pkg::MIN_MAG_RESET;
        end
        else if (cfg.valid)
        begin
            min_mag_reg <= cfg.min_magnitude;
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
            for (int i = 0; i <= RS; i++)
            begin
                r_vld_reg[i] <= 1'b0;
            end
            for (int i = 0; i <= DS; i++)
            begin
                d_vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            a_vld_reg    <= vec_in.valid;
            b_vld_reg    <= a_vld_reg;
            r_vld_reg[0] <= b_vld_reg;
            for (int i = 1; i <= RS; i++)
            begin
                r_vld_reg[i] <= r_vld_reg[i-1];
            end
            d_vld_reg[0] <= r_vld_reg[RS];
            for (int i = 1; i <= DS; i++)
            begin
                d_vld_reg[i] <= d_vld_reg[i-1];
            end
            o_vld_reg <= d_vld_reg[DS];
        end
    end

    // Root recurrence: one result bit per stage from the remainder.
    always_comb
    begin
        r_n_next[0]    = '0;
        r_rem_next[0]  = '0;
        r_root_next[0] = '0;
        for (int i = 1; i <= RS; i++)
        begin
            logic [REM_W-1:0] rs;
            logic [REM_W-1:0] test;
            rs   = {r_rem_reg[i-1][REM_W-3:0], r_n_reg[i-1][SQ_W-1 -: 2]};
            test = {r_root_reg[i-1], 2'b01};
            r_n_next[i] = {r_n_reg[i-1][SQ_W-3:0], 2'b00};
            if (rs >= test)
            begin
                r_rem_next[i]  = rs - test;
                r_root_next[i] = {r_root_reg[i-1][MAG_W-2:0], 1'b1};
            end
            else
            begin
                r_rem_next[i]  = rs;
                r_root_next[i] = {r_root_reg[i-1][MAG_W-2:0], 1'b0};
            end
        end
    end

    // Rounded numerator: component shifted up plus half the magnitude.
    assign fin_mag = r_root_reg[RS];
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            num_next[c] = {r_abs_reg[RS][c], {vn_pkg::FRAC_BITS{1'b0}}}
                          + NUM_W'(fin_mag >> 1);
        end
    end

    // The quotient stays below two units, so the first partial remainder
    // is already below the magnitude and only Q_W steps remain.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            d_rem_next[0][c] = '0;
            d_low_next[0][c] = '0;
            d_q_next[0][c]   = '0;
        end
        for (int i = 1; i <= DS; i++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                logic [MAG_W:0] rs;
                rs = {d_rem_reg[i-1][c], d_low_reg[i-1][c][Q_W-1]};
                d_low_next[i][c] = {d_low_reg[i-1][c][Q_W-2:0], 1'b0};
                if (rs >= {1'b0, d_mag_reg[i-1]})
                begin
                    d_rem_next[i][c] = MAG_W'(rs - {1'b0, d_mag_reg[i-1]});
                    d_q_next[i][c]   = {d_q_reg[i-1][c][Q_W-2:0], 1'b1};
                end
                else
                begin
                    d_rem_next[i][c] = rs[MAG_W-1:0];
                    d_q_next[i][c]   = {d_q_reg[i-1][c][Q_W-2:0], 1'b0};
                end
            end
        end
    end

    // Saturate to one unit, apply sign, or force zero for a short vector.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            logic [Q_W-1:0] q;
            q = (d_q_reg[DS][c] > vn_pkg::UNIT_ONE) ? vn_pkg::UNIT_ONE : d_q_reg[DS][c];
            if (d_short_reg[DS])
            begin
                o_unit_next[c] = '0;
            end
            else if (d_sgn_reg[DS][c])
            begin
                o_unit_next[c] = OUT_W'(0) - OUT_W'(q);
            end
            else
            begin
                o_unit_next[c] = OUT_W'(q);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                a_abs_reg[c] <= comp_in[c][vn_pkg::IN_W-1] ? ABS_W'(-comp_in[c])
                                                          : ABS_W'(comp_in[c]);
                a_sgn_reg[c] <= comp_in[c][vn_pkg::IN_W-1];
                b_sq_reg[c]  <= a_abs_reg[c] * a_abs_reg[c];
                b_abs_reg[c] <= a_abs_reg[c];
            end
            b_sgn_reg <= a_sgn_reg;

            r_n_reg[0]    <= b_sq_reg[0] + b_sq_reg[1] + b_sq_reg[2];
            r_rem_reg[0]  <= '0;
            r_root_reg[0] <= '0;
            r_abs_reg[0]  <= b_abs_reg;
            r_sgn_reg[0]  <= b_sgn_reg;
            for (int i = 1; i <= RS; i++)
            begin
                r_n_reg[i]    <= r_n_next[i];
                r_rem_reg[i]  <= r_rem_next[i];
                r_root_reg[i] <= r_root_next[i];
                r_abs_reg[i]  <= r_abs_reg[i-1];
                r_sgn_reg[i]  <= r_sgn_reg[i-1];
            end

            d_mag_reg[0]   <= fin_mag;
            d_short_reg[0] <= fin_mag <= MAG_W'(min_mag_reg);
            d_sgn_reg[0]   <= r_sgn_reg[RS];
            for (int c = 0; c < 3; c++)
            begin
                d_rem_reg[0][c] <= MAG_W'(num_next[c][NUM_W-1:Q_W]);
                d_low_reg[0][c] <= num_next[c][Q_W-1:0];
                d_q_reg[0][c]   <= '0;
            end
            for (int i = 1; i <= DS; i++)
            begin
                d_mag_reg[i]   <= d_mag_reg[i-1];
                d_short_reg[i] <= d_short_reg[i-1];
                d_sgn_reg[i]   <= d_sgn_reg[i-1];
                for (int c = 0; c < 3; c++)
                begin
                    d_rem_reg[i][c] <= d_rem_next[i][c];
                    d_low_reg[i][c] <= d_low_next[i][c];
                    d_q_reg[i][c]   <= d_q_next[i][c];
                end
            end

            o_unit_reg  <= o_unit_next;
            o_short_reg <= d_short_reg[DS];
        end
    end

    assign vec_out.valid     = o_vld_reg;
    assign vec_out.x_unit    = o_unit_reg[0];
    assign vec_out.y_unit    = o_unit_reg[1];
    assign vec_out.z_unit    = o_unit_reg[2];
    assign vec_out.too_short = o_short_reg;

    assign out_zero     = (vec_out.x_unit == '0) && (vec_out.y_unit == '0)
                          && (vec_out.z_unit == '0);
    assign out_in_range = (vec_out.x_unit <= 18'sd65536) && (vec_out.x_unit >= -18'sd65536)
                          && (vec_out.y_unit <= 18'sd65536) && (vec_out.y_unit >= -18'sd65536)
                          && (vec_out.z_unit <= 18'sd65536) && (vec_out.z_unit >= -18'sd65536);
    assign out_stall    = vec_out.valid && !vec_out.ready;

    `VN_ASSERT_SAME(a_short_zero, vec_out.valid && vec_out.too_short, out_zero)
    `VN_ASSERT_SAME(a_unit_range, vec_out.valid, out_in_range)
    `VN_ASSERT_NEXT(a_stall_freeze, out_stall, $stable(d_vld_reg[DS]) && $stable(r_vld_reg[RS]))
endmodule
`default_nettype wire
